@@ src/rif_pkg.sv @@
package rif_pkg;

    // Default sizes of the formatter.
    localparam int VALUE_BITS_DEF  = 31;
    localparam int DIGIT_SLOTS_DEF = 32;

    // Fixed field widths.
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    typedef logic [RADIX_W-1:0] radix_t;
    typedef logic [CHAR_W-1:0]  char_t;

    // Radix limits and reset value.
    localparam radix_t RADIX_RESET = 6'd10;
    localparam radix_t RADIX_MIN   = 6'd2;
    localparam radix_t RADIX_MAX   = 6'd36;
    localparam radix_t DEC_DIGITS  = 6'd10;

    // Character codes.
    localparam char_t ASCII_ZERO = 7'd48;
    localparam char_t ASCII_UC_A = 7'd65;

    // Control from the sequencer to the digit store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctl_t;

    // Clamp the radix register into the legal range of bases.
    function automatic radix_t eff_radix(input radix_t r);
        radix_t res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    // Map a digit value to its character.
    function automatic char_t to_ascii(input radix_t d);
        char_t res;
        if (d < DEC_DIGITS) begin
            res = ASCII_ZERO + char_t'(d);
        end else begin
            res = ASCII_UC_A + char_t'(d - DEC_DIGITS);
        end
        return res;
    endfunction

endpackage

@@ src/rif_divider.sv @@
module rif_divider #(
    parameter int VALUE_BITS = rif_pkg::VALUE_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [VALUE_BITS-1:0]   dividend,
    input  rif_pkg::radix_t         divisor,
    output logic                    done,
    output logic [VALUE_BITS-1:0]   quotient,
    output rif_pkg::radix_t         remainder
);
    import rif_pkg::*;

    localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    radix_t                rem_reg, rem_next;
    radix_t                dvs_reg, dvs_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [RADIX_W:0]      trial;
    logic                  fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(VALUE_BITS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[VALUE_BITS-2:0], fits};
            if (fits) begin
                rem_next = RADIX_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[RADIX_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Busy and done are reset; the datapath registers and the bit counter are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ src/rif_digit_store.sv @@
module rif_digit_store #(
    parameter int DIGIT_SLOTS = rif_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                           aclk,
    input  rif_pkg::store_ctl_t            ctl,
    input  logic [$clog2(DIGIT_SLOTS)-1:0] wr_addr,
    input  rif_pkg::radix_t                wr_data,
    input  logic [$clog2(DIGIT_SLOTS)-1:0] rd_addr,
    output rif_pkg::radix_t                rd_data
);
    import rif_pkg::*;

    radix_t mem [DIGIT_SLOTS];
    radix_t rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/radix_integer_formatter.sv @@
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_value
// m_       out        m_valid/m_ready    m_digit_char, m_last_digit
// cfg_     in         cfg_we             cfg_wdata (radix)
//
// Each digit is produced by the bit-serial restoring divider, then read back
// from the digit store in reverse order, after all digits of the item are stored.
// Reset is synchronous and active low; the digit store needs no clearing.
// A stall on m_ready holds the output register and the emit sequence; the
// next item is taken while the last digit still waits in the output register.
module radix_integer_formatter #(
    parameter int VALUE_BITS  = rif_pkg::VALUE_BITS_DEF,
    parameter int DIGIT_SLOTS = rif_pkg::DIGIT_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  rif_pkg::radix_t       cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rif_pkg::char_t        m_digit_char,
    output logic                  m_last_digit
);
    import rif_pkg::*;

    localparam int IDX_W = $clog2(DIGIT_SLOTS);
    localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_inc, cnt_dec;
    radix_t           radix_reg;
    logic             out_valid_reg, out_valid_next;
    char_t            out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;
    logic             out_load;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quotient;
    radix_t                div_remainder;
    store_ctl_t            store_ctl;
    radix_t                rd_data;

    assign cnt_inc = cnt_reg + 1'b1;
    assign cnt_dec = cnt_reg - 1'b1;

    // Radix register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_we) begin
            radix_reg <= cfg_wdata;
        end
    end

    rif_divider #(
        .VALUE_BITS(VALUE_BITS)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (eff_radix(radix_reg)),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    rif_digit_store #(
        .DIGIT_SLOTS(DIGIT_SLOTS)
    ) u_store (
        .aclk    (aclk),
        .ctl     (store_ctl),
        .wr_addr (cnt_reg[IDX_W-1:0]),
        .wr_data (div_remainder),
        .rd_addr (cnt_dec[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Sequencer: divide digit by digit, then read the digits back in reverse.
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        div_start       = 1'b0;
        div_dividend    = s_value;
        store_ctl.wr_en = 1'b0;
        store_ctl.rd_en = 1'b0;
        out_load        = 1'b0;
        s_ready         = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    div_start  = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    store_ctl.wr_en = 1'b1;
                    cnt_next        = cnt_inc;
                    if ((|div_quotient) && (cnt_inc < CNT_W'(DIGIT_SLOTS))) begin
                        div_start    = 1'b1;
                        div_dividend = div_quotient;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                store_ctl.rd_en = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_load = 1'b1;
                    cnt_next = cnt_dec;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register next values.
    always_comb begin
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_char_next  = to_ascii(rd_data);
            out_last_next  = (cnt_reg == CNT_W'(1));
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_digit_char = out_char_reg;
    assign m_last_digit = out_last_reg;

endmodule

@@ src/rif_checker.sv @@
module rif_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input rif_pkg::char_t        m_digit_char,
    input logic                  m_last_digit
);
    import rif_pkg::*;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digit_char) && $stable(m_last_digit))
        else $error("result changed while stalled");

    // Every shown character is a digit or an upper-case letter.
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_digit_char >= 7'd48 && m_digit_char <= 7'd57) ||
                     (m_digit_char >= 7'd65 && m_digit_char <= 7'd90)))
        else $error("result character out of range");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // The input side reopens only when the final digit has been loaded.
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_ready) |-> m_valid && m_last_digit)
        else $error("input reopened before final digit");

endmodule

bind radix_integer_formatter rif_checker u_rif_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_digit_char (m_digit_char),
    .m_last_digit (m_last_digit)
);
